// File: rtl/mnss_pkg.sv
// Package for the note-sequenced sine tone generator.
// Holds item types, register codes, reset values, the semitone table and note lookups.
// Used by midi_note_sine_synth_unit; depends on nothing else.
`default_nettype none

package mnss_pkg;

  localparam int FADE_SPAN        = 200;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_A4_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE     = 2'd1,
    CFG_SLOT_LEN      = 2'd2
  } cfg_index_t;

  localparam logic [31:0] A4_PHASE_STEP_RESET = 32'd39370534;
  localparam logic [14:0] AMPLITUDE_RESET     = 15'd6553;
  localparam logic [19:0] SLOT_LEN_RESET      = 20'd4800;

  typedef struct packed {
    logic [6:0] note_number;
    logic       is_rest;
  } note_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               note_end;
  } sample_item_t;

  typedef struct packed {
    logic [19:0] position_in_note;
    logic [31:0] phase;
    logic [31:0] current_step;
    logic        current_silent;
  } voice_state_t;

  localparam voice_state_t VOICE_RESET = '{
    position_in_note: 20'd0,
    phase:            32'd0,
    current_step:     32'd0,
    current_silent:   1'b1
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } seq_state_t;

  // Ratios 2^(k/12) in unsigned Q1.15, rounded to nearest.
  localparam logic [15:0] SEMITONE_Q15 [12] = '{
    16'd32768, 16'd34716, 16'd36781, 16'd38968, 16'd41285, 16'd43740,
    16'd46341, 16'd49097, 16'd52016, 16'd55109, 16'd58386, 16'd61858
  };

  typedef logic [3:0] note_semi_tab_t  [128];
  typedef logic [4:0] note_shift_tab_t [128];

  // Semitone within the octave, counted from A.
  function automatic note_semi_tab_t build_note_semi();
    note_semi_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 4'((i + 3) % 12);
    end
    return t;
  endfunction

  // Right shift of the scaled step, 15 minus the octave offset from A4.
  function automatic note_shift_tab_t build_note_shift();
    note_shift_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 5'(21 - (i + 3) / 12);
    end
    return t;
  endfunction

  localparam note_semi_tab_t  NOTE_SEMI  = build_note_semi();
  localparam note_shift_tab_t NOTE_SHIFT = build_note_shift();

endpackage

`default_nettype wire

// File: rtl/midi_note_sine_synth_unit.sv
// Top level of the note-sequenced sine tone generator (phase accumulator and sine table).
// Depends on mnss_pkg for item types, register codes and note lookup tables.
//
//   Channel   Direction  Handshake                  Payload
//   note      in         note_valid / note_stall    mnss_pkg::note_item_t
//   sample    out        sample_valid / sample_stall mnss_pkg::sample_item_t
//   cfg       in         cfg_we                     cfg_index, cfg_data
//
// Each item passes through accept with the voice state read, then load, multiply,
// scale and write back, run by one sequencer around the one-entry voice state memory.
// The result sits in an output register, so the next item is accepted while it waits.
// A stall on the sample channel holds the sequencer in write-back until the register frees.
// Synchronous reset restores the registers and marks the voice state memory unwritten,
// which then reads as the reset voice state; no clearing pass is needed.
`default_nettype none

module midi_note_sine_synth_unit #(
  parameter int FadeLen   = mnss_pkg::FADE_SPAN,
  parameter int SineDepth = mnss_pkg::SINE_TABLE_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 note_valid,
  output logic                                note_stall,
  input  mnss_pkg::note_item_t                note_item,
  output logic                                sample_valid,
  input  wire                                 sample_stall,
  output mnss_pkg::sample_item_t              sample_item,
  input  wire                                 cfg_we,
  input  wire [mnss_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [mnss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mnss_pkg::*;

  localparam int IDX_W     = $clog2(SineDepth);
  localparam int DEP_W     = $clog2(SineDepth + 1);
  localparam int IPROD_W   = 32 + DEP_W;
  localparam int FADE_W    = $clog2(FadeLen + 1);
  localparam int FADE_N    = 15 + FADE_W;
  localparam int FADE_S    = FADE_N + $clog2(FadeLen);
  localparam int FADE_M_W  = FADE_N + 2;
  localparam int FADE_P_W  = FADE_N + FADE_M_W;
  localparam logic [FADE_M_W-1:0] FADE_M =
    FADE_M_W'(((64'd1 << FADE_S) / FadeLen) + 1);

  typedef logic signed [15:0] sine_lut_t [SineDepth];

  // Quarter-wave folded odd polynomial in Q28 coefficients, worked out at elaboration.
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   t;
    logic [63:0] u, x, x2, p, y;
    logic [1:0]  quad;
    for (int i = 0; i < SineDepth; i++) begin
      u    = (64'(i) * 64'd65536) / 64'(SineDepth);
      quad = u[15:14];
      x    = u & 64'h3FFF;
      if (quad[0]) x = 64'd16384 - x;
      x2 = (x * x) >> 14;
      p  = 64'd1256735 - ((x2 * 64'd43057) >> 14);
      p  = 64'd21392319 - ((x2 * p) >> 14);
      p  = 64'd173399668 - ((x2 * p) >> 14);
      p  = 64'd421657421 - ((x2 * p) >> 14);
      y  = (x * p) >> 27;
      if (y > 64'd32767) y = 64'd32767;
      t[i] = quad[1] ? -$signed(16'(y)) : $signed(16'(y));
    end
    return t;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  logic [31:0] a4_phase_step;
  logic [14:0] amplitude;
  logic [19:0] slot_len;

  seq_state_t state, state_next;

  voice_state_t voice_mem [1];
  voice_state_t voice_q;
  logic         voice_written;
  voice_state_t voice_wb;
  logic         mem_we;

  logic [6:0]  note_q;
  logic        rest_q;
  logic        first_q;
  logic        silent_q;
  logic [31:0] phase_q;
  logic [31:0] old_step_q;
  logic [47:0] step_prod_q;
  logic [4:0]  shift_q;
  logic        fade_q;
  logic [FADE_N-1:0]   fade_x_q;
  logic [FADE_P_W-1:0] gain_prod_q;
  logic [IPROD_W-1:0]  idx_prod_q;
  logic [19:0] pos_next_q;
  logic        last_q;
  logic [31:0] step_q;
  logic signed [15:0] sine_q;
  logic [29:0] mag_prod_q;
  logic        neg_q;

  voice_state_t cur;
  logic         first;
  logic [31:0]  phase_e;
  logic [19:0]  len;
  logic [19:0]  remaining;
  logic [20:0]  pos_inc;
  logic         last;
  logic [FADE_W-1:0] rem_c;
  logic [47:0]  step_sh;
  logic [IDX_W-1:0] sine_idx;
  logic [14:0]  gain;
  logic [14:0]  sine_abs;
  logic [14:0]  mag;
  logic signed [15:0] smp;
  logic         out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a4_phase_step <= A4_PHASE_STEP_RESET;
      amplitude     <= AMPLITUDE_RESET;
      slot_len      <= SLOT_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A4_PHASE_STEP: a4_phase_step <= cfg_data;
        CFG_AMPLITUDE:     amplitude     <= cfg_data[14:0];
        CFG_SLOT_LEN:      slot_len      <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    note_stall = 1'b1;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        note_stall = 1'b0;
        if (note_valid) state_next = ST_LOAD;
      end
      ST_LOAD:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE: begin
        if (!sample_valid || !sample_stall) begin
          out_load   = 1'b1;
          mem_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && note_valid) begin
      voice_q <= voice_mem[0];
      note_q  <= note_item.note_number;
      rest_q  <= note_item.is_rest;
    end
    if (mem_we) begin
      voice_mem[0] <= voice_wb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_written <= 1'b0;
    end else if (mem_we) begin
      voice_written <= 1'b1;
    end
  end

  always_comb begin
    cur       = voice_written ? voice_q : VOICE_RESET;
    first     = (cur.position_in_note == 20'd0);
    phase_e   = first ? 32'd0 : cur.phase;
    len       = (slot_len == 20'd0) ? 20'd1 : slot_len;
    remaining = (cur.position_in_note < len) ? (len - cur.position_in_note) : 20'd1;
    pos_inc   = {1'b0, cur.position_in_note} + 21'd1;
    last      = (pos_inc >= {1'b0, len});
    rem_c     = FADE_W'(remaining);
    step_sh   = step_prod_q >> shift_q;
    sine_idx  = idx_prod_q[32 +: IDX_W];
    gain      = fade_q ? 15'(gain_prod_q >> FADE_S) : amplitude;
    sine_abs  = sine_q[15] ? 15'(-sine_q) : sine_q[14:0];
    mag       = mag_prod_q[29:15];
    smp       = silent_q ? 16'sd0 : (neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        first_q     <= first;
        silent_q    <= first ? rest_q : cur.current_silent;
        phase_q     <= phase_e;
        old_step_q  <= cur.current_step;
        step_prod_q <= 48'(a4_phase_step) * 48'(SEMITONE_Q15[NOTE_SEMI[note_q]]);
        shift_q     <= NOTE_SHIFT[note_q];
        fade_q      <= ({12'd0, remaining} <= 32'(FadeLen));
        fade_x_q    <= FADE_N'(amplitude) * FADE_N'(rem_c);
        idx_prod_q  <= IPROD_W'(phase_e) * IPROD_W'(SineDepth);
        pos_next_q  <= last ? 20'd0 : pos_inc[19:0];
        last_q      <= last;
      end
      ST_MUL: begin
        step_q      <= first_q ? ((|step_sh[47:32]) ? 32'hFFFF_FFFF : step_sh[31:0])
                               : old_step_q;
        sine_q      <= SINE_LUT[sine_idx];
        gain_prod_q <= FADE_P_W'(fade_x_q) * FADE_P_W'(FADE_M);
      end
      ST_SCALE: begin
        mag_prod_q <= 30'(gain) * 30'(sine_abs);
        neg_q      <= sine_q[15];
      end
      default: ;
    endcase
  end

  always_comb begin
    voice_wb.position_in_note = pos_next_q;
    voice_wb.phase            = silent_q ? phase_q : phase_q + step_q;
    voice_wb.current_step     = step_q;
    voice_wb.current_silent   = silent_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (out_load) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_item.sample   <= smp;
      sample_item.note_end <= last_q;
    end
  end

  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    note_valid && !note_stall |=> ##3 state == ST_DONE)
    else $error("accepted item did not reach write-back on time");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> 32'(sine_idx) < 32'(SineDepth))
    else $error("sine table index out of range");

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCALE |-> gain <= amplitude)
    else $error("fade gain exceeds amplitude");

  a_rest_silent: assert property (@(posedge clk) disable iff (rst)
    out_load && silent_q |=> sample_item.sample == 16'sd0)
    else $error("silent slot produced a nonzero sample");

  a_wb_wraps_on_end: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (voice_mem[0].position_in_note == 20'd0) == sample_item.note_end)
    else $error("note end and stored position disagree");

endmodule

`default_nettype wire
